FILE: rtl/isoe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isoe_pkg
// Shared types, codes and sizes of the integer stack operation engine.
// ----------------------------------------------------------------------------
package isoe_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned DATA_W      = 32;

  localparam logic [2:0] MODE_PUSH = 3'd0;
  localparam logic [2:0] MODE_DUMP = 3'd1;
  localparam logic [2:0] MODE_PEEK = 3'd2;
  localparam logic [2:0] MODE_POP  = 3'd3;
  localparam logic [2:0] MODE_SWAP = 3'd4;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_OPERAND = 3'd1;
  localparam logic [2:0] ST_PEEK_EMPTY  = 3'd2;
  localparam logic [2:0] ST_POP_EMPTY   = 3'd3;
  localparam logic [2:0] ST_SWAP_SHORT  = 3'd4;
  localparam logic [2:0] ST_OVERFLOW    = 3'd5;
  localparam logic [2:0] ST_HALTED      = 3'd6;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] operand;
    logic               operand_ok;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] element;
    logic               has_element;
    logic [2:0]         status;
    logic               last;
  } out_word_t;

endpackage

FILE: rtl/isoe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isoe_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module isoe_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/integer_stack_op_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_stack_op_engine_core
// Bounded LIFO stack of signed words kept in one synchronous RAM, with push,
// dump, peek, pop and swap commands and a sticky halt on any error.
// ----------------------------------------------------------------------------
//  channel   ports                               handshake
//  command   start_i, in_word_i, busy_o          taken when start_i && !busy_o
//  result    res_valid_o, res_word_o             one-cycle strobe, no stall
//
//  push, pop, unused modes and halted answers: result on the next cycle.
//  peek: waits in S_PEEK for the registered RAM read. swap: S_SWAP_A,
//  S_SWAP_B, S_SWAP_C (two reads and two writes through the single RAM port
//  pair). dump of n words: one word per cycle from the RAM read port.
//  reset clears the state, count, index, halt flag and result valid; the RAM is not cleared.
// ----------------------------------------------------------------------------
module integer_stack_op_engine_core #(
  parameter int unsigned StackDepth = isoe_pkg::STACK_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  isoe_pkg::in_word_t  in_word_i,
  output logic                busy_o,
  output logic                res_valid_o,
  output isoe_pkg::out_word_t res_word_o
);

  localparam int unsigned AddrW = $clog2(StackDepth);
  localparam int unsigned CntW  = $clog2(StackDepth + 1);
  localparam int unsigned DataW = isoe_pkg::DATA_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PEEK   = 6'b000010,
    S_DUMP   = 6'b000100,
    S_SWAP_A = 6'b001000,
    S_SWAP_B = 6'b010000,
    S_SWAP_C = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                halted_q, halted_d;
  logic [AddrW-1:0]    idx_q, idx_d;
  logic [DataW-1:0]    top_q, top_d;
  logic                res_valid_q, res_valid_d;
  isoe_pkg::out_word_t res_q, res_d;

  logic                we;
  logic [AddrW-1:0]    waddr;
  logic [DataW-1:0]    wdata;
  logic                re;
  logic [AddrW-1:0]    raddr;
  logic [DataW-1:0]    rdata;
  logic [CntW-1:0]     cnt_m1;
  logic [CntW-1:0]     cnt_m2;

  assign cnt_m1 = count_q - CntW'(1);
  assign cnt_m2 = count_q - CntW'(2);

  isoe_ram #(
    .Width (DataW),
    .Depth (StackDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    halted_d    = halted_q;
    idx_d       = idx_q;
    top_d       = top_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    we          = 1'b0;
    waddr       = count_q[AddrW-1:0];
    wdata       = in_word_i.operand;
    re          = 1'b0;
    raddr       = cnt_m1[AddrW-1:0];

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          res_d.element     = '0;
          res_d.has_element = 1'b0;
          res_d.status      = isoe_pkg::ST_OK;
          res_d.last        = 1'b1;
          if (halted_q) begin
            res_valid_d  = 1'b1;
            res_d.status = isoe_pkg::ST_HALTED;
          end else begin
            case (in_word_i.mode)
              isoe_pkg::MODE_PUSH: begin
                res_valid_d = 1'b1;
                if (!in_word_i.operand_ok) begin
                  res_d.status = isoe_pkg::ST_BAD_OPERAND;
                  halted_d     = 1'b1;
                end else if (count_q == CntW'(StackDepth)) begin
                  res_d.status = isoe_pkg::ST_OVERFLOW;
                  halted_d     = 1'b1;
                end else begin
                  we      = 1'b1;
                  count_d = count_q + CntW'(1);
                end
              end
              isoe_pkg::MODE_DUMP: begin
                if (count_q != '0) begin
                  re      = 1'b1;
                  idx_d   = cnt_m1[AddrW-1:0];
                  state_d = S_DUMP;
                end
              end
              isoe_pkg::MODE_PEEK: begin
                if (count_q == '0) begin
                  res_valid_d  = 1'b1;
                  res_d.status = isoe_pkg::ST_PEEK_EMPTY;
                  halted_d     = 1'b1;
                end else begin
                  re      = 1'b1;
                  state_d = S_PEEK;
                end
              end
              isoe_pkg::MODE_POP: begin
                res_valid_d = 1'b1;
                if (count_q == '0) begin
                  res_d.status = isoe_pkg::ST_POP_EMPTY;
                  halted_d     = 1'b1;
                end else begin
                  count_d = cnt_m1;
                end
              end
              isoe_pkg::MODE_SWAP: begin
                if (count_q < CntW'(2)) begin
                  res_valid_d  = 1'b1;
                  res_d.status = isoe_pkg::ST_SWAP_SHORT;
                  halted_d     = 1'b1;
                end else begin
                  re      = 1'b1;
                  state_d = S_SWAP_A;
                end
              end
              default: begin
                res_valid_d = 1'b1;
              end
            endcase
          end
        end
      end
      S_PEEK: begin
        res_valid_d       = 1'b1;
        res_d.element     = rdata;
        res_d.has_element = 1'b1;
        res_d.status      = isoe_pkg::ST_OK;
        res_d.last        = 1'b1;
        state_d           = S_IDLE;
      end
      S_DUMP: begin
        res_valid_d       = 1'b1;
        res_d.element     = rdata;
        res_d.has_element = 1'b1;
        res_d.status      = isoe_pkg::ST_OK;
        res_d.last        = (idx_q == '0);
        if (idx_q == '0) begin
          state_d = S_IDLE;
        end else begin
          re    = 1'b1;
          raddr = idx_q - AddrW'(1);
          idx_d = idx_q - AddrW'(1);
        end
      end
      S_SWAP_A: begin
        top_d   = rdata;
        re      = 1'b1;
        raddr   = cnt_m2[AddrW-1:0];
        state_d = S_SWAP_B;
      end
      S_SWAP_B: begin
        we      = 1'b1;
        waddr   = cnt_m1[AddrW-1:0];
        wdata   = rdata;
        state_d = S_SWAP_C;
      end
      S_SWAP_C: begin
        we                = 1'b1;
        waddr             = cnt_m2[AddrW-1:0];
        wdata             = top_q;
        res_valid_d       = 1'b1;
        res_d.element     = '0;
        res_d.has_element = 1'b0;
        res_d.status      = isoe_pkg::ST_OK;
        res_d.last        = 1'b1;
        state_d           = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      halted_q    <= 1'b0;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      halted_q    <= halted_d;
      idx_q       <= idx_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    res_q <= res_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_word_o  = res_q;

endmodule
